>>> rtl/core/bond_present_value_core_macros.svh
// Assertion shorthands for the bond pricing core. Every user has clk and
// arst_n in scope; checks are off while reset is applied.
`ifndef BOND_PRESENT_VALUE_CORE_MACROS_SVH
`define BOND_PRESENT_VALUE_CORE_MACROS_SVH

// Same-cycle implication
`define BPV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BPV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/bpv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpv_pkg;

	// Field widths
	localparam int N_W          = 10;
	localparam int FREQ_W       = 4;
	localparam int BP_W         = 14;
	localparam int PAR_W        = 20;
	localparam int PRICE_W      = 47;
	localparam int FRAC_W       = 32;
	localparam int PRICE_FRAC_W = 16;

	// Q32 value in [0, 1.0], bit FRAC_W marks exactly 1.0
	localparam int Q_W     = FRAC_W + 1;
	localparam int FUNIT_W = 17;
	localparam int DEN1_W  = 18;
	localparam int DEN2_W  = 17;

	localparam logic [FREQ_W-1:0]  FREQ_MAX    = 4'd12;
	localparam logic [FUNIT_W-1:0] BP_PER_UNIT = 17'd10000;
	localparam logic [Q_W-1:0]     Q_ONE       = 33'h1_0000_0000;
	localparam logic [PRICE_W-1:0] PRICE_MAX   = '1;
	localparam logic [PAR_W-1:0]   PAR_RESET   = 20'd100;

	typedef logic [Q_W-1:0] q32_t;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic               bad_frequency;
	} bpv_result_t;

endpackage

`default_nettype wire

>>> rtl/core/bpv_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Bond description word
interface bpv_item_if import bpv_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [N_W-1:0]    period_count;
	logic [FREQ_W-1:0] coupons_per_year;
	logic [BP_W-1:0]   yield_bp;
	logic [BP_W-1:0]   coupon_bp;

	modport source (output valid, period_count, coupons_per_year, yield_bp, coupon_bp,
		input ready);
	modport sink (input valid, period_count, coupons_per_year, yield_bp, coupon_bp,
		output ready);
endinterface

// Price word
interface bpv_result_if import bpv_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] price;
	logic               bad_frequency;

	modport source (output valid, price, bad_frequency, input ready);
	modport sink (input valid, price, bad_frequency, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bpv_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage. The caller guarantees
// num >> QUO_W < den, so QUO_W stages give the full quotient.
module bpv_div import bpv_pkg::*; #(
	parameter int NUM_W = 50,
	parameter int QUO_W = 33,
	parameter int DEN_W = 18,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_valid,
	output logic [QUO_W-1:0] quo,
	output logic [TAG_W-1:0] tag_out
);

	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] low_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [TAG_W-1:0] tag_s [QUO_W];
	logic [QUO_W-1:0] v_s;

	logic [DEN_W-1:0] src_rem [QUO_W];
	logic [QUO_W-1:0] src_low [QUO_W];
	logic [DEN_W-1:0] src_den [QUO_W];
	logic [TAG_W-1:0] src_tag [QUO_W];
	logic [DEN_W:0]   trial   [QUO_W];
	logic [DEN_W-1:0] rem_nx  [QUO_W];
	logic [QUO_W-1:0] low_nx  [QUO_W];
	logic [QUO_W-1:0] src_v;

	// Pick each stage's source: ports for the first, previous stage otherwise
	always_comb begin
		src_rem[0] = DEN_W'(num >> QUO_W);
		src_low[0] = num[QUO_W-1:0];
		src_den[0] = den;
		src_tag[0] = tag_in;
		for (int k = 1; k < QUO_W; k++) begin
			src_rem[k] = rem_s[k-1];
			src_low[k] = low_s[k-1];
			src_den[k] = den_s[k-1];
			src_tag[k] = tag_s[k-1];
		end
		src_v = {v_s[QUO_W-2:0], in_valid};
	end

	// One shift-and-subtract step per stage
	always_comb begin
		for (int k = 0; k < QUO_W; k++) begin
			trial[k] = {src_rem[k], src_low[k][QUO_W-1]};
			if (trial[k] >= {1'b0, src_den[k]}) begin
				rem_nx[k] = DEN_W'(trial[k] - {1'b0, src_den[k]});
				low_nx[k] = {src_low[k][QUO_W-2:0], 1'b1};
			end else begin
				rem_nx[k] = DEN_W'(trial[k]);
				low_nx[k] = {src_low[k][QUO_W-2:0], 1'b0};
			end
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QUO_W; k++) begin
				rem_s[k] <= rem_nx[k];
				low_s[k] <= low_nx[k];
				den_s[k] <= src_den[k];
				tag_s[k] <= src_tag[k];
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= src_v;
		end
	end

	assign out_valid = v_s[QUO_W-1];
	assign quo       = low_s[QUO_W-1];
	assign tag_out   = tag_s[QUO_W-1];

endmodule

`default_nettype wire

>>> rtl/core/bpv_pow.sv
`timescale 1ns / 1ps
`default_nettype none

// Discount factor base^expo by square and multiply, one exponent bit per
// pair of stages: multiply stage, then round and select stage.
module bpv_pow import bpv_pkg::*; #(
	parameter int EXP_W = 10,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  q32_t             base,
	input  logic [EXP_W-1:0] expo,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_valid,
	output q32_t             disc,
	output logic [TAG_W-1:0] tag_out
);

	localparam int P_W = 2 * FRAC_W;

	// Q32 product with 1.0 passing the other operand through
	function automatic q32_t mul_sel(q32_t a, q32_t b, logic [P_W-1:0] p);
		logic [P_W-1:0] r;
		r = p + (P_W'(1) << (FRAC_W - 1));
		if (a[FRAC_W])
			return b;
		if (b[FRAC_W])
			return a;
		return {1'b0, r[P_W-1:FRAC_W]};
	endfunction

	// Multiply stages
	logic [P_W-1:0]   pd_sa  [EXP_W];
	logic [P_W-1:0]   pb_sa  [EXP_W];
	q32_t             dsc_sa [EXP_W];
	q32_t             bas_sa [EXP_W];
	logic [EXP_W-1:0] exp_sa [EXP_W];
	logic [TAG_W-1:0] tag_sa [EXP_W];
	logic [EXP_W-1:0] va_s;

	// Select stages
	q32_t             dsc_sb [EXP_W];
	q32_t             bas_sb [EXP_W];
	logic [EXP_W-1:0] exp_sb [EXP_W];
	logic [TAG_W-1:0] tag_sb [EXP_W];
	logic [EXP_W-1:0] vb_s;

	q32_t             src_dsc [EXP_W];
	q32_t             src_bas [EXP_W];
	logic [EXP_W-1:0] src_exp [EXP_W];
	logic [TAG_W-1:0] src_tag [EXP_W];
	logic [EXP_W-1:0] src_v;
	logic [P_W-1:0]   pd_nx   [EXP_W];
	logic [P_W-1:0]   pb_nx   [EXP_W];
	q32_t             dsc_nx  [EXP_W];
	q32_t             bas_nx  [EXP_W];

	// Sources and products
	always_comb begin
		src_dsc[0] = Q_ONE;
		src_bas[0] = base;
		src_exp[0] = expo;
		src_tag[0] = tag_in;
		src_v[0]   = in_valid;
		for (int i = 1; i < EXP_W; i++) begin
			src_dsc[i] = dsc_sb[i-1];
			src_bas[i] = bas_sb[i-1];
			src_exp[i] = exp_sb[i-1];
			src_tag[i] = tag_sb[i-1];
			src_v[i]   = vb_s[i-1];
		end
		for (int i = 0; i < EXP_W; i++) begin
			pd_nx[i] = src_dsc[i][FRAC_W-1:0] * src_bas[i][FRAC_W-1:0];
			pb_nx[i] = src_bas[i][FRAC_W-1:0] * src_bas[i][FRAC_W-1:0];
		end
	end

	// Round, then take the product where the exponent bit asks for it
	always_comb begin
		for (int i = 0; i < EXP_W; i++) begin
			dsc_nx[i] = exp_sa[i][i] ? mul_sel(dsc_sa[i], bas_sa[i], pd_sa[i]) : dsc_sa[i];
			bas_nx[i] = mul_sel(bas_sa[i], bas_sa[i], pb_sa[i]);
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < EXP_W; i++) begin
				pd_sa[i]  <= pd_nx[i];
				pb_sa[i]  <= pb_nx[i];
				dsc_sa[i] <= src_dsc[i];
				bas_sa[i] <= src_bas[i];
				exp_sa[i] <= src_exp[i];
				tag_sa[i] <= src_tag[i];
				dsc_sb[i] <= dsc_nx[i];
				bas_sb[i] <= bas_nx[i];
				exp_sb[i] <= exp_sa[i];
				tag_sb[i] <= tag_sa[i];
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s <= '0;
			vb_s <= '0;
		end else if (en) begin
			va_s <= src_v;
			vb_s <= va_s;
		end
	end

	assign out_valid = vb_s[EXP_W-1];
	assign disc      = dsc_sb[EXP_W-1];
	assign tag_out   = tag_sb[EXP_W-1];

endmodule

`default_nettype wire

>>> rtl/core/bpv_price.sv
`timescale 1ns / 1ps
`default_nettype none

// Price = par * (term + disc) scaled from Q32 to Q16, rounded, saturated; zero for a bad word.
module bpv_price import bpv_pkg::*; #(
	parameter int TERM_W = 47
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [TERM_W-1:0] term,
	input  q32_t              disc,
	input  logic              bad,
	input  logic [PAR_W-1:0]  par,
	output logic              out_valid,
	output bpv_result_t       result
);

	localparam int F_W   = TERM_W + 1;
	localparam int HI_W  = PAR_W + F_W - PRICE_FRAC_W;
	localparam int LO_W  = PAR_W + PRICE_FRAC_W;
	localparam int SUM_W = HI_W + 1;

	logic [F_W-1:0]   f_s1;
	logic             bad_s1, bad_s2, bad_s3;
	logic [HI_W-1:0]  hi_s2;
	logic [LO_W-1:0]  lo_s2;
	logic [PRICE_W-1:0] price_s3;
	logic             v_s1, v_s2, v_s3;

	logic [LO_W:0]    lo_r;
	logic [SUM_W-1:0] sum;

	// Round the fraction part and add it to the integer part
	always_comb begin
		lo_r = (LO_W+1)'(lo_s2) + (LO_W+1)'(1 << (PRICE_FRAC_W - 1));
		sum  = SUM_W'(hi_s2) + SUM_W'(lo_r >> PRICE_FRAC_W);
	end

	// Sum, multiply, then saturate or zero a bad word
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1   <= F_W'(term) + F_W'(disc);
			bad_s1 <= bad;
			hi_s2  <= par * f_s1[F_W-1:PRICE_FRAC_W];
			lo_s2  <= par * f_s1[PRICE_FRAC_W-1:0];
			bad_s2 <= bad_s1;
			if (bad_s2)
				price_s3 <= '0;
			else if (sum > SUM_W'(PRICE_MAX))
				price_s3 <= PRICE_MAX;
			else
				price_s3 <= sum[PRICE_W-1:0];
			bad_s3 <= bad_s2;
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign out_valid            = v_s3;
	assign result.price         = price_s3;
	assign result.bad_frequency = bad_s3;

endmodule

`default_nettype wire

>>> rtl/core/bond_present_value_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bond_present_value_core_macros.svh"

// Fixed-coupon bond pricer. Takes one bond word per cycle unless stalled and
// returns one price word per bond, in order, with 16 fractional bits,
// saturating at its maximum; a coupon frequency of 0 or above 12 returns
// price 0 with bad_frequency set. Its depth comes mostly from the
// one-bit-per-stage dividers for the one-period discount factor (33 stages)
// and the coupon term (47 stages) and from two stages per exponent bit of
// the discount power. A two-word output queue decouples the pipeline from
// the result consumer; the pipeline stalls only when the queue is full.
// par_value is written through cfg_wr_en and cfg_wr_data, by the user only
// while no bond is in flight (not enforced by the block); it resets to 100.
module bond_present_value_core import bpv_pkg::*; #(
	parameter int MAX_PERIODS = 1023
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [PAR_W-1:0]   cfg_wr_data,
	bpv_item_if.sink           item_in,
	bpv_result_if.source       result_out
);

	localparam int NB       = $clog2(MAX_PERIODS + 1);
	localparam int NW       = (NB > N_W) ? NB : N_W;
	localparam int NUM1_W   = FUNIT_W + FRAC_W + 1;
	localparam int PM_W     = BP_W + Q_W;
	localparam int NUM2_W   = BP_W + NB + FRAC_W + 1;
	localparam int TERM_W   = (FRAC_W + 1 + NB > PM_W) ? FRAC_W + 1 + NB : PM_W;
	localparam int TAG1_W   = NB + 2 * BP_W + FUNIT_W + 1;
	localparam int TAG2_W   = Q_W + 1;
	localparam logic [NW-1:0] MAXP = NW'(MAX_PERIODS);
	localparam logic [1:0]    FIFO_FULL = 2'd2;

	logic             en;
	logic [PAR_W-1:0] par_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q <= PAR_RESET;
		end else if (cfg_wr_en) begin
			par_q <= cfg_wr_data;
		end
	end

	// Input stage: saturate n, form frequency scale and first division operands
	logic [NW-1:0]      n_ext, n_sat;
	logic [FUNIT_W-1:0] funit;
	logic [DEN1_W-1:0]  den1;

	always_comb begin
		n_ext = NW'(item_in.period_count);
		n_sat = (n_ext > MAXP) ? MAXP : n_ext;
		funit = FUNIT_W'(item_in.coupons_per_year) * BP_PER_UNIT;
		den1  = DEN1_W'(funit) + DEN1_W'(item_in.yield_bp);
	end

	logic [NUM1_W-1:0]  num1_s1;
	logic [DEN1_W-1:0]  den1_s1;
	logic [TAG1_W-1:0]  tag1_s1;
	logic               v_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s1 <= (NUM1_W'(funit) << FRAC_W) + NUM1_W'(den1 >> 1);
			den1_s1 <= den1;
			tag1_s1 <= {n_sat[NB-1:0], item_in.coupon_bp, item_in.yield_bp, funit,
				(item_in.coupons_per_year == '0) || (item_in.coupons_per_year > FREQ_MAX)};
		end
	end

	// One-period discount factor
	logic              d1_valid;
	logic [Q_W-1:0]    d1_quo;
	logic [TAG1_W-1:0] d1_tag;
	q32_t              d1_base;

	bpv_div #(
		.NUM_W (NUM1_W),
		.QUO_W (Q_W),
		.DEN_W (DEN1_W),
		.TAG_W (TAG1_W)
	) u_div_d1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.num       (num1_s1),
		.den       (den1_s1),
		.tag_in    (tag1_s1),
		.out_valid (d1_valid),
		.quo       (d1_quo),
		.tag_out   (d1_tag)
	);

	assign d1_base = (d1_quo > Q_ONE) ? Q_ONE : d1_quo;

	// Discount factor over n periods
	logic              pw_valid;
	q32_t              pw_disc;
	logic [TAG1_W-1:0] pw_tag;

	bpv_pow #(
		.EXP_W (NB),
		.TAG_W (TAG1_W)
	) u_pow (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d1_valid),
		.base      (d1_base),
		.expo      (d1_tag[TAG1_W-1 -: NB]),
		.tag_in    (d1_tag),
		.out_valid (pw_valid),
		.disc      (pw_disc),
		.tag_out   (pw_tag)
	);

	logic [NB-1:0]      n_p;
	logic [BP_W-1:0]    c_p, y_p;
	logic [FUNIT_W-1:0] fu_p;
	logic               bad_p;
	q32_t               mul_b;

	assign {n_p, c_p, y_p, fu_p, bad_p} = pw_tag;
	assign mul_b = (y_p != '0) ? (Q_ONE - pw_disc) : Q_W'(n_p);

	// Coupon numerator product
	logic [PM_W-1:0]    pm_s2;
	logic [BP_W-1:0]    y_s2;
	logic [FUNIT_W-1:0] fu_s2;
	q32_t               disc_s2;
	logic               bad_s2, v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pm_s2   <= c_p * mul_b;
			y_s2    <= y_p;
			fu_s2   <= fu_p;
			disc_s2 <= pw_disc;
			bad_s2  <= bad_p;
		end
	end

	// Coupon division operands with rounding offset
	logic [NUM2_W-1:0] num2_s3;
	logic [DEN2_W-1:0] den2_s3;
	logic [TAG2_W-1:0] tag2_s3;
	logic              v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_s2 != '0) begin
				num2_s3 <= NUM2_W'(pm_s2) + NUM2_W'(y_s2 >> 1);
				den2_s3 <= DEN2_W'(y_s2);
			end else begin
				num2_s3 <= (NUM2_W'(pm_s2[BP_W+NB-1:0]) << FRAC_W) + NUM2_W'(fu_s2 >> 1);
				den2_s3 <= fu_s2;
			end
			tag2_s3 <= {disc_s2, bad_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_in.valid;
			v_s2 <= pw_valid;
			v_s3 <= v_s2;
		end
	end

	// Coupon term
	logic              tm_valid;
	logic [TERM_W-1:0] tm_quo;
	logic [TAG2_W-1:0] tm_tag;

	bpv_div #(
		.NUM_W (NUM2_W),
		.QUO_W (TERM_W),
		.DEN_W (DEN2_W),
		.TAG_W (TAG2_W)
	) u_div_term (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (num2_s3),
		.den       (den2_s3),
		.tag_in    (tag2_s3),
		.out_valid (tm_valid),
		.quo       (tm_quo),
		.tag_out   (tm_tag)
	);

	// Scale by par
	logic        res_valid;
	bpv_result_t res;

	bpv_price #(
		.TERM_W (TERM_W)
	) u_price (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (tm_valid),
		.term      (tm_quo),
		.disc      (tm_tag[TAG2_W-1:1]),
		.bad       (tm_tag[0]),
		.par       (par_q),
		.out_valid (res_valid),
		.result    (res)
	);

	// Two-word output queue
	bpv_result_t fifo_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	assign en   = (cnt_q != FIFO_FULL);
	assign push = en && res_valid;
	assign pop  = result_out.valid && result_out.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	assign item_in.ready            = en;
	assign result_out.valid         = (cnt_q != '0);
	assign result_out.price         = fifo_q[rd_ptr_q].price;
	assign result_out.bad_frequency = fifo_q[rd_ptr_q].bad_frequency;

	`BPV_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= FIFO_FULL, "output queue overflow")
	`BPV_ASSERT_IMP(a_bad_zero, result_out.valid && result_out.bad_frequency, result_out.price == '0, "bad frequency word with nonzero price")
	`BPV_ASSERT_NXT(a_hold_last, res_valid && !en, res_valid, "stalled pipeline dropped a word")
	`BPV_ASSERT_NXT(a_cnt_down, pop && !push, cnt_q == $past(cnt_q) - 2'd1, "queue count lost a pop")

endmodule

`default_nettype wire

>>> tb/sv/bond_price_checker.sv
`timescale 1ns / 1ps

// Watch the bond and price channels, predict each price and compare in order
module bond_price_checker import bpv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [PAR_W-1:0] cfg_wr_data,
	bpv_item_if              bonds,
	bpv_result_if            prices,
	output int               error_count,
	output int               words_in_flight
);

	localparam int          PERIOD_CAP = 1023;
	localparam logic [63:0] UNIT_Q32   = 64'd1 << 32;
	localparam logic [63:0] TOP_PRICE  = (64'd1 << PRICE_W) - 64'd1;

	logic [PAR_W-1:0] par_q;
	bpv_result_t      expected_prices[$];

	// Q32 product; an operand at 1.0 passes the other one through
	function automatic logic [63:0] q32_mul(logic [63:0] a, logic [63:0] b);
		if (a >= UNIT_Q32) return b;
		if (b >= UNIT_Q32) return a;
		return (a * b + (UNIT_Q32 >> 1)) >> 32;
	endfunction

	function automatic logic [63:0] div_half_up(logic [63:0] num, logic [63:0] den);
		return (num + den / 2) / den;
	endfunction

	// Price one bond word with the annuity formula
	function automatic bpv_result_t price_bond(logic [N_W-1:0] periods,
			logic [FREQ_W-1:0] freq, logic [BP_W-1:0] yld, logic [BP_W-1:0] cpn,
			logic [PAR_W-1:0] par);
		logic [63:0] n, f_unit, d1, disc, base, e, term, f, price;
		bpv_result_t r;
		r = '0;
		if (freq == 0 || freq > FREQ_MAX) begin
			r.bad_frequency = 1'b1;
			return r;
		end
		n = 64'(periods);
		if (n > PERIOD_CAP) n = PERIOD_CAP;
		f_unit = 64'd10000 * freq;
		d1 = div_half_up(f_unit << 32, f_unit + yld);
		if (d1 > UNIT_Q32) d1 = UNIT_Q32;
		// square and multiply for the discount power
		disc = UNIT_Q32;
		base = d1;
		e = n;
		while (e != 0) begin
			if (e[0]) disc = q32_mul(disc, base);
			base = q32_mul(base, base);
			e = e >> 1;
		end
		if (yld != 0) term = div_half_up(64'(cpn) * (UNIT_Q32 - disc), 64'(yld));
		else term = div_half_up((64'(cpn) * n) << 32, f_unit);
		f = term + disc;
		price = par * (f >> 16) + ((par * (f & 64'hFFFF) + 64'h8000) >> 16);
		if (price > TOP_PRICE) price = TOP_PRICE;
		r.price = price[PRICE_W-1:0];
		return r;
	endfunction

	// Track par, queue predictions, compare each price word against the oldest
	always @(posedge clk or negedge arst_n) begin
		bpv_result_t exp_w;
		int pushed, popped;
		if (!arst_n) begin
			par_q <= PAR_RESET;
			error_count <= 0;
			words_in_flight <= 0;
		end else begin
			pushed = 0;
			popped = 0;
			if (cfg_wr_en) par_q <= cfg_wr_data;
			if (bonds.valid && bonds.ready) begin
				expected_prices.push_back(price_bond(bonds.period_count,
					bonds.coupons_per_year, bonds.yield_bp, bonds.coupon_bp, par_q));
				pushed = 1;
			end
			if (prices.valid && prices.ready) begin
				if (expected_prices.size() == 0) begin
					$display("%0t: unexpected price word price=%0d bad_frequency=%0b",
						$time, prices.price, prices.bad_frequency);
					error_count <= error_count + 1;
				end else begin
					exp_w = expected_prices.pop_front();
					popped = 1;
					if (exp_w.price !== prices.price ||
							exp_w.bad_frequency !== prices.bad_frequency) begin
						$display("%0t: price mismatch expected price=%0d bad=%0b",
							$time, exp_w.price, exp_w.bad_frequency,
							" actual price=%0d bad=%0b",
							prices.price, prices.bad_frequency);
						error_count <= error_count + 1;
					end
				end
			end
			words_in_flight <= words_in_flight + pushed - popped;
		end
	end

endmodule

>>> tb/sv/tb_bond_present_value_core.sv
`timescale 1ns / 1ps

module tb_bond_present_value_core;
	import bpv_pkg::*;

	localparam int DRAIN_CYCLES = 150;
	localparam int CYCLE_LIMIT  = 400000;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [PAR_W-1:0] cfg_wr_data;
	int               error_count;
	int               words_in_flight;
	int               cycle_count = 0;
	bit               steady_feed;

	bpv_item_if   bond_if();
	bpv_result_if price_if();

	bond_present_value_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item_in(bond_if),
		.result_out(price_if)
	);

	bond_price_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.bonds(bond_if),
		.prices(price_if),
		.error_count(error_count),
		.words_in_flight(words_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Stall the price channel: mostly short, now and then long
	initial begin
		int pick;
		price_if.ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				price_if.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				price_if.ready <= 1'b0;
				repeat (pick < 9 ? $urandom_range(1, 3) : $urandom_range(10, 60))
					@(posedge clk);
			end
		end
	end

	// Hold the word until accepted, then maybe drop valid for a gap
	task automatic send_bond(logic [N_W-1:0] n, logic [FREQ_W-1:0] freq,
			logic [BP_W-1:0] yld, logic [BP_W-1:0] cpn);
		int pick;
		bond_if.valid <= 1'b1;
		bond_if.period_count <= n;
		bond_if.coupons_per_year <= freq;
		bond_if.yield_bp <= yld;
		bond_if.coupon_bp <= cpn;
		do @(posedge clk); while (!bond_if.ready);
		pick = $urandom_range(0, 19);
		if (!steady_feed && pick >= 12) begin
			bond_if.valid <= 1'b0;
			repeat (pick < 18 ? $urandom_range(1, 3) : $urandom_range(10, 40))
				@(posedge clk);
		end
	endtask

	// Drain the pipeline, then write par
	task automatic write_par(logic [PAR_W-1:0] value);
		bond_if.valid <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_random(int count);
		logic [FREQ_W-1:0] freq;
		logic [BP_W-1:0] yld;
		logic [BP_W-1:0] cpn;
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 19);
			freq = (pick == 0) ? FREQ_W'($urandom_range(13, 15)) :
				(pick == 1) ? 4'd0 : FREQ_W'($urandom_range(1, 12));
			pick = $urandom_range(0, 9);
			yld = (pick == 0) ? 14'd0 :
				(pick == 1) ? BP_W'($urandom_range(0, 16383)) :
				BP_W'($urandom_range(1, 10000));
			cpn = ($urandom_range(0, 9) == 0) ? BP_W'($urandom_range(0, 16383)) :
				BP_W'($urandom_range(0, 10000));
			send_bond(N_W'($urandom_range(0, 1023)), freq, yld, cpn);
		end
	endtask

	initial begin
		steady_feed = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		bond_if.valid = 1'b0;
		bond_if.period_count = '0;
		bond_if.coupons_per_year = '0;
		bond_if.yield_bp = '0;
		bond_if.coupon_bp = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edge cases at the reset par
		send_bond(10'd10, 4'd2, 14'd500, 14'd500);
		send_bond(10'd0, 4'd1, 14'd500, 14'd500);
		send_bond(10'd1023, 4'd12, 14'd10000, 14'd10000);
		send_bond(10'd1023, 4'd1, 14'd1, 14'd16383);
		send_bond(10'd1023, 4'd12, 14'd0, 14'd16383);
		send_bond(10'd20, 4'd4, 14'd0, 14'd300);
		send_bond(10'd30, 4'd1, 14'd0, 14'd0);
		send_bond(10'd30, 4'd2, 14'd400, 14'd0);
		send_bond(10'd30, 4'd0, 14'd400, 14'd400);
		send_bond(10'd30, 4'd13, 14'd400, 14'd400);
		send_bond(10'd30, 4'd15, 14'd400, 14'd400);
		send_bond(10'd1, 4'd12, 14'd16383, 14'd16383);
		send_bond(10'd1, 4'd1, 14'd16383, 14'd0);
		send_bond(10'd512, 4'd6, 14'd8191, 14'd8192);
		send_bond(10'd1023, 4'd1, 14'd0, 14'd16383);
		send_random(40);

		write_par(20'd1);
		send_random(100);
		write_par(20'hFFFFF);
		steady_feed = 1'b1;
		send_random(60);
		steady_feed = 1'b0;
		send_bond(10'd1023, 4'd12, 14'd0, 14'd16383);
		send_bond(10'd500, 4'd1, 14'd1, 14'd16383);
		send_random(40);
		write_par(20'd1000000);
		send_random(100);
		write_par(PAR_W'($urandom_range(1, 1000000)));
		send_random(100);

		// Wait for the last prices
		bond_if.valid <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
